### hw/rtl/frbp_pkg.sv
package frbp_pkg;

  // Field widths of the stream payloads
  localparam int unsigned OP_W      = 2;
  localparam int unsigned NOW_W     = 32;
  localparam int unsigned OUTCOME_W = 2;
  localparam int unsigned ERR_W     = 8;
  localparam int unsigned RND_W     = 32;
  localparam int unsigned CLASS_W   = 2;
  localparam int unsigned DELAY_W   = 13;
  localparam int unsigned WINDOW_W  = 17;
  localparam int unsigned EPCNT_W   = 8;

  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 16;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 17;
  localparam logic [CFG_ADDR_W-1:0] REG_CLIENT_HOLD = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_LIFE    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ENDPOINTS   = 2'd2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_BEGIN    = 2'd0;
  localparam logic [OP_W-1:0] OP_CLASSIFY = 2'd1;
  localparam logic [OP_W-1:0] OP_WAIT     = 2'd2;

  // Fetch outcome codes
  localparam logic [OUTCOME_W-1:0] OUTCOME_SUCCESS  = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUTCOME_DECLINED = 2'd1;

  // Linux errno values that matter to the policy
  localparam logic [ERR_W-1:0] ERR_EPERM   = 8'd1;
  localparam logic [ERR_W-1:0] ERR_ENOENT  = 8'd2;
  localparam logic [ERR_W-1:0] ERR_EACCES  = 8'd13;
  localparam logic [ERR_W-1:0] ERR_ENOTDIR = 8'd20;
  localparam logic [ERR_W-1:0] ERR_EBADMSG = 8'd74;

  typedef enum logic [CLASS_W-1:0] {
    CLASS_OK         = 2'd0,
    CLASS_DEFINITIVE = 2'd1,
    CLASS_RETRY      = 2'd2
  } fill_class_t;

  // Status of the remainder unit
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### hw/rtl/frbp_classify.sv
module frbp_classify (
  input  logic [frbp_pkg::OUTCOME_W-1:0] outcome,
  input  logic [frbp_pkg::ERR_W-1:0]     err_code,
  input  logic [frbp_pkg::EPCNT_W-1:0]   verify_left,
  output frbp_pkg::fill_class_t          fill_class,
  output logic                           spend
);

  // Map outcome and errno to a class; a digest mismatch spends budget while budget is left
  always_comb begin
    spend = 1'b0;
    priority if (outcome == frbp_pkg::OUTCOME_SUCCESS ||
                 outcome == frbp_pkg::OUTCOME_DECLINED) begin
      fill_class = frbp_pkg::CLASS_OK;
    end else if (err_code == frbp_pkg::ERR_ENOENT || err_code == frbp_pkg::ERR_ENOTDIR ||
                 err_code == frbp_pkg::ERR_EACCES || err_code == frbp_pkg::ERR_EPERM) begin
      fill_class = frbp_pkg::CLASS_DEFINITIVE;
    end else if (err_code == frbp_pkg::ERR_EBADMSG) begin
      if (verify_left != '0) begin
        fill_class = frbp_pkg::CLASS_RETRY;
        spend      = 1'b1;
      end else begin
        fill_class = frbp_pkg::CLASS_DEFINITIVE;
      end
    end else begin
      fill_class = frbp_pkg::CLASS_RETRY;
    end
  end

endmodule

### hw/rtl/frbp_divider.sv
module frbp_divider #(
  parameter int unsigned DW = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [frbp_pkg::RND_W-1:0]  dividend,
  input  logic [DW-1:0]               divisor,
  output frbp_pkg::div_stat_t         stat,
  output logic [DW-1:0]               remainder
);

  localparam int unsigned CW = $clog2(frbp_pkg::RND_W);

  logic [frbp_pkg::RND_W-1:0] dvd_sh;
  logic [DW-1:0]              dvs;
  logic [DW-1:0]              rem;
  logic [CW-1:0]              cnt;
  logic                       busy;
  logic [DW:0]                trial;
  logic                       last;

  assign trial = {rem, dvd_sh[frbp_pkg::RND_W-1]};
  assign last  = (cnt == CW'(frbp_pkg::RND_W - 1));

  // Control: one quotient bit per cycle, most significant first
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (last) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath: shift in a dividend bit, subtract when the trial fits
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_sh <= dividend;
      dvs    <= divisor;
      rem    <= '0;
    end else if (busy) begin
      dvd_sh <= {dvd_sh[frbp_pkg::RND_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        rem <= DW'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[DW-1:0];
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = busy && last;
  assign remainder = rem;

endmodule

### hw/rtl/fill_retry_backoff_policy_core.sv
// Retry policy core: begin, classify and wait operations on one stream.
// Begin and classify register their result through the emit state; a granted wait
// first runs the 32 one-bit steps of the remainder unit that forms the jitter;
// a refused wait goes straight to the emit state.
// Throughput: one item at a time, input ready again once its result is registered.
// Reset (rst, synchronous) clears config to its defaults, backoff and budget state.
module fill_retry_backoff_policy_core #(
  parameter int unsigned BACKOFF_START_MS = 250,
  parameter int unsigned BACKOFF_CAP_MS   = 8000
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // tuser: operation[1:0]
  input  logic [frbp_pkg::OP_W-1:0]         s_tuser,
  // tdata: now_s[31:0], fill_outcome[33:32], err_code[41:34],
  //        waiters_present[42], random_value[74:43], zero fill[79:75]
  input  logic [frbp_pkg::IN_DATA_W-1:0]    s_tdata,
  // Result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // tdata: fill_class[1:0], wait_granted[2], delay_ms[15:3]
  output logic [frbp_pkg::OUT_DATA_W-1:0]   m_tdata,
  // Configuration writes
  input  logic                              cfg_we,
  input  logic [frbp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [frbp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int unsigned BMAX = (BACKOFF_START_MS > BACKOFF_CAP_MS) ?
                                 BACKOFF_START_MS : BACKOFF_CAP_MS;
  localparam int unsigned BW   = $clog2(BMAX + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state;

  // Configuration registers
  logic [frbp_pkg::WINDOW_W-1:0] client_hold_s;
  logic [frbp_pkg::WINDOW_W-1:0] max_life_s;
  logic [frbp_pkg::EPCNT_W-1:0]  endpoint_count;

  // Policy state
  logic [frbp_pkg::NOW_W-1:0]    start_time;
  logic [BW-1:0]                 backoff_now;
  logic [frbp_pkg::EPCNT_W-1:0]  verify_left;

  // Result holding
  frbp_pkg::fill_class_t         res_class;
  logic                          res_granted;
  logic [BW-1:0]                 half;

  // Input fields
  logic [frbp_pkg::OP_W-1:0]      op;
  logic [frbp_pkg::NOW_W-1:0]     now_s;
  logic [frbp_pkg::OUTCOME_W-1:0] fill_outcome;
  logic [frbp_pkg::ERR_W-1:0]     err_code;
  logic                           waiters_present;
  logic [frbp_pkg::RND_W-1:0]     random_value;

  assign op              = s_tuser;
  assign now_s           = s_tdata[31:0];
  assign fill_outcome    = s_tdata[33:32];
  assign err_code        = s_tdata[41:34];
  assign waiters_present = s_tdata[42];
  assign random_value    = s_tdata[74:43];

  logic                          accept;
  logic [frbp_pkg::WINDOW_W-1:0] window;
  logic [frbp_pkg::NOW_W:0]      window_end;
  logic                          grant;
  logic [BW:0]                   doubled;
  logic [BW-1:0]                 backoff_next;
  logic [BW-1:0]                 half_now;
  logic                          div_start;
  frbp_pkg::div_stat_t           dstat;
  logic [BW-1:0]                 rem;
  frbp_pkg::fill_class_t         cls;
  logic                          spend;
  logic [BW:0]                   delay_sum;
  logic [frbp_pkg::DELAY_W-1:0]  delay_ms;
  logic                          out_free;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Window check: end of window formed one bit wider so it never wraps
  assign window     = waiters_present ? client_hold_s : max_life_s;
  assign window_end = {1'b0, start_time} + (frbp_pkg::NOW_W + 1)'(window);
  assign grant      = (window != '0) && ({1'b0, now_s} < window_end);

  // Backoff growth, limited by the cap
  assign half_now     = backoff_now >> 1;
  assign doubled      = {backoff_now, 1'b0};
  assign backoff_next = (doubled < (BW + 1)'(BACKOFF_CAP_MS)) ? doubled[BW-1:0]
                                                              : BW'(BACKOFF_CAP_MS);
  assign div_start    = accept && (op == frbp_pkg::OP_WAIT) && grant;

  frbp_classify u_classify (
    .outcome     (fill_outcome),
    .err_code    (err_code),
    .verify_left (verify_left),
    .fill_class  (cls),
    .spend       (spend)
  );

  frbp_divider #(
    .DW (BW)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (random_value),
    .divisor   (BW'(half_now + 1'b1)),
    .stat      (dstat),
    .remainder (rem)
  );

  // Configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      client_hold_s  <= '0;
      max_life_s     <= '0;
      endpoint_count <= frbp_pkg::EPCNT_W'(1);
    end else if (cfg_we) begin
      if (cfg_addr == frbp_pkg::REG_CLIENT_HOLD) begin
        client_hold_s <= cfg_wdata;
      end
      if (cfg_addr == frbp_pkg::REG_MAX_LIFE) begin
        max_life_s <= cfg_wdata;
      end
      if (cfg_addr == frbp_pkg::REG_ENDPOINTS) begin
        endpoint_count <= cfg_wdata[frbp_pkg::EPCNT_W-1:0];
      end
    end
  end

  // Sequencer and policy state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      start_time  <= '0;
      backoff_now <= BW'(BACKOFF_START_MS);
      verify_left <= frbp_pkg::EPCNT_W'(1);
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EMIT;
            if (op == frbp_pkg::OP_BEGIN) begin
              start_time  <= now_s;
              backoff_now <= BW'(BACKOFF_START_MS);
              verify_left <= (endpoint_count != '0) ? endpoint_count
                                                    : frbp_pkg::EPCNT_W'(1);
            end else if (op == frbp_pkg::OP_CLASSIFY) begin
              if (spend) begin
                verify_left <= verify_left - 1'b1;
              end
            end else if (op == frbp_pkg::OP_WAIT && grant) begin
              backoff_now <= backoff_next;
              state       <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (dstat.done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Capture the result fields of the accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      res_class   <= (op == frbp_pkg::OP_CLASSIFY) ? cls : frbp_pkg::CLASS_OK;
      res_granted <= div_start;
      half        <= half_now;
    end
  end

  // Delay in [half, 2 * half], masked to the field width
  assign delay_sum = {1'b0, half} + {1'b0, rem};
  assign delay_ms  = res_granted ? frbp_pkg::DELAY_W'(delay_sum) : '0;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      m_tdata <= {delay_ms, res_granted, res_class};
    end
  end

  // Checks
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    dstat.busy |-> !s_tready)
    else $error("input ready while the remainder unit runs");

  a_refused_no_delay: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[2]) |-> (m_tdata[15:3] == '0))
    else $error("delay given on a refused or non-wait result");

  a_grant_class_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2]) |-> (m_tdata[1:0] == frbp_pkg::CLASS_OK))
    else $error("class set on a wait result");

  a_backoff_capped: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (backoff_now <= BW'(BACKOFF_CAP_MS)))
    else $error("backoff above cap after a grant");

endmodule
